// File: hw/rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque
// Request mode, side and status codes, and the control word that travels
// along the storage cell chain together with each request.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int MODE_W   = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;
   localparam int CAP_MAX  = (1 << CAP_W) - 1;

   localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

   localparam logic SIDE_FRONT = 1'b0;
   localparam logic SIDE_REAR  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // Control word of one request as it moves down the cell chain.
   typedef struct packed {
      logic                valid;
      logic                wr;
      logic                rd;
      logic [STATUS_W-1:0] status;
      logic [CAP_W-1:0]    occupancy;
   } ctl_type;

endpackage

// File: hw/rtl/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell: one storage entry of the deque
// Holds one entry. A request passing by that addresses this cell writes the
// entry or picks up its value; the request moves on to the next cell.
// ----------------------------------------------------------------------------
module cdq_cell #(
   parameter int INDEX = 0,
   parameter int PTR_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cdq_pkg::ctl_type            ctl_in,
   input  logic [PTR_W-1:0]            addr_in,
   input  logic [cdq_pkg::DATA_W-1:0]  data_in,
   output cdq_pkg::ctl_type            ctl_out,
   output logic [PTR_W-1:0]            addr_out,
   output logic [cdq_pkg::DATA_W-1:0]  data_out
);

   logic                       hit;
   logic [cdq_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic [cdq_pkg::DATA_W-1:0] data_ff, data_in_nxt;
   logic [PTR_W-1:0]           addr_ff;
   cdq_pkg::ctl_type           ctl_ff;

   assign hit         = ctl_in.valid && (addr_in == PTR_W'(INDEX));
   assign entry_in    = (hit && ctl_in.wr) ? data_in : entry_ff;
   assign data_in_nxt = (hit && ctl_in.rd) ? entry_ff : data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      data_ff  <= data_in_nxt;
      addr_ff  <= addr_in;
   end

   assign ctl_out  = ctl_ff;
   assign addr_out = addr_ff;
   assign data_out = data_ff;

endmodule

// File: hw/rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: pointer and count control of the deque
// Keeps the front and rear pointers, the entry count and the capacity
// register, decides each request and issues it into the cell chain.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [cdq_pkg::MODE_W-1:0]    req_mode,
   input  logic                          req_side,
   input  logic signed [cdq_pkg::DATA_W-1:0] req_push_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0]     csr_wdata,
   output cdq_pkg::ctl_type              ctl_out,
   output logic [PTR_W-1:0]              addr_out,
   output logic [cdq_pkg::DATA_W-1:0]    data_out
);

   localparam int CAP_W   = cdq_pkg::CAP_W;
   localparam int CMP_W   = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
   localparam int CAP_RST = (DEPTH > cdq_pkg::CAP_MAX) ? cdq_pkg::CAP_MAX : DEPTH;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CAP_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] rear_ff, rear_in;
   logic [CAP_W-1:0] eff_cap;
   logic             full, empty;
   logic [PTR_W-1:0] front_back;
   logic [PTR_W-1:0] rear_back;

   cdq_pkg::ctl_type           ctl_ff, ctl_in;
   logic [PTR_W-1:0]           addr_ff, addr_in;
   logic [cdq_pkg::DATA_W-1:0] data_ff;

   // Wrap forward at the capacity.
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] n;
      n = CMP_W'(p) + CMP_W'(1);
      return (n >= CMP_W'(cap)) ? '0 : PTR_W'(n);
   endfunction

   // Wrap backward from zero to capacity - 1.
   function automatic logic [PTR_W-1:0] retreat(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] m;
      m = CMP_W'(cap) - CMP_W'(1);
      return (p == '0) ? PTR_W'(m) : p - PTR_W'(1);
   endfunction

   // Zero acts as one, anything above the storage size as the storage size.
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (32'(capacity_ff) > DEPTH) begin
         eff_cap = CAP_W'(CAP_RST);
      end else begin
         eff_cap = capacity_ff;
      end
   end

   assign full       = count_ff >= eff_cap;
   assign empty      = count_ff == '0;
   assign front_back = retreat(front_ff, eff_cap);
   assign rear_back  = retreat(rear_ff, eff_cap);

   assign csr_ready   = 1'b1;
   assign capacity_in = csr_valid ? csr_wdata : capacity_ff;

   always_comb begin
      front_in      = front_ff;
      rear_in       = rear_ff;
      count_in      = count_ff;
      addr_in       = '0;
      ctl_in        = '0;
      ctl_in.valid  = accept;
      ctl_in.status = cdq_pkg::STAT_OK;
      case (req_mode)
         cdq_pkg::MODE_PUSH: begin
            if (full) begin
               ctl_in.status = cdq_pkg::STAT_FULL;
            end else begin
               ctl_in.wr = 1'b1;
               count_in  = count_ff + CAP_W'(1);
               if (req_side == cdq_pkg::SIDE_FRONT) begin
                  addr_in  = front_ff;
                  front_in = advance(front_ff, eff_cap);
               end else begin
                  addr_in = rear_back;
                  rear_in = rear_back;
               end
            end
         end
         cdq_pkg::MODE_POP, cdq_pkg::MODE_PEEK: begin
            if (empty) begin
               ctl_in.status = cdq_pkg::STAT_EMPTY;
            end else begin
               ctl_in.rd = 1'b1;
               if (req_side == cdq_pkg::SIDE_FRONT) begin
                  addr_in = front_back;
                  if (req_mode == cdq_pkg::MODE_POP) begin
                     front_in = front_back;
                     count_in = count_ff - CAP_W'(1);
                  end
               end else begin
                  addr_in = rear_ff;
                  if (req_mode == cdq_pkg::MODE_POP) begin
                     rear_in  = advance(rear_ff, eff_cap);
                     count_in = count_ff - CAP_W'(1);
                  end
               end
            end
         end
         default: begin
            // unused mode: no change, plain ok answer
         end
      endcase
      ctl_in.occupancy = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RST);
         count_ff    <= '0;
         front_ff    <= '0;
         rear_ff     <= '0;
         ctl_ff      <= '0;
      end else begin
         capacity_ff <= capacity_in;
         ctl_ff      <= ctl_in;
         if (accept) begin
            count_ff <= count_in;
            front_ff <= front_in;
            rear_ff  <= rear_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      data_ff <= req_push_value;
   end

   assign ctl_out  = ctl_ff;
   assign addr_out = addr_ff;
   assign data_out = data_ff;

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == cdq_pkg::MODE_PUSH) && !full
      |=> count_ff == $past(count_ff) + CAP_W'(1))
      else $error("accepted push did not raise the count");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_mode == cdq_pkg::MODE_PUSH && full) ||
                 (req_mode != cdq_pkg::MODE_PUSH && empty))
      |=> $stable(count_ff) && $stable(front_ff) && $stable(rear_ff))
      else $error("refused request changed the deque state");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (32'(front_ff) < DEPTH) && (32'(rear_ff) < DEPTH))
      else $error("pointer beyond storage");

endmodule

// File: hw/rtl/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue in a circular buffer
// Push, pop or peek at either end of a deque of 32-bit signed values.
// ----------------------------------------------------------------------------
// Usage:
//   Requests: a transfer happens at a rising edge with start high and busy
//   low. busy stays low: the unit takes a new request in every cycle.
//   req_mode selects push, pop or peek, req_side the front or rear end,
//   req_push_value is the value stored by a push.
//   Results: one per request, in request order, on the rsp_ ports for one
//   cycle with rsp_strobe high. The receiver cannot stall; it must take each
//   result in the cycle it is shown.
//   Path: the request is registered in the controller, then walks through
//   the row of DEPTH storage cells in order (one cell per cycle) to the
//   result ports. Throughput: one request per cycle.
//   Configuration: csr_wdata writes the capacity (wrap point of both
//   pointers) when csr_valid is high; csr_ready is always high. Write it only
//   while no request is in flight.
//   Reset: pointers and count go to zero, capacity to DEPTH (31 at most),
//   the chain empties. Storage entries keep whatever they held.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [cdq_pkg::MODE_W-1:0]           req_mode,
   input  logic                                 req_side,
   input  logic signed [cdq_pkg::DATA_W-1:0]    req_push_value,
   output logic                                 rsp_strobe,
   output logic signed [cdq_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [cdq_pkg::STATUS_W-1:0]         rsp_status,
   output logic [cdq_pkg::CAP_W-1:0]            rsp_occupancy,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0]            csr_wdata
);

   localparam int PTR_W = $clog2(DEPTH);

   logic accept;

   // Link i feeds cell i; link DEPTH is the end of the chain.
   cdq_pkg::ctl_type           ctl_link  [DEPTH+1];
   logic [PTR_W-1:0]           addr_link [DEPTH+1];
   logic [cdq_pkg::DATA_W-1:0] data_link [DEPTH+1];

   // Each request costs one cell step per cycle, so nothing ever backs up.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Controller: decides the request now and issues one control word into
   // the chain, with the entry address and the push value.
   cdq_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_mode       (req_mode),
      .req_side       (req_side),
      .req_push_value (req_push_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .ctl_out        (ctl_link[0]),
      .addr_out       (addr_link[0]),
      .data_out       (data_link[0])
   );

   // Storage row: the request passes every cell in order, so a later read
   // always sees an earlier write to the same entry.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cdq_cell #(
         .INDEX (i),
         .PTR_W (PTR_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (ctl_link[i]),
         .addr_in  (addr_link[i]),
         .data_in  (data_link[i]),
         .ctl_out  (ctl_link[i+1]),
         .addr_out (addr_link[i+1]),
         .data_out (data_link[i+1])
      );
   end

   // Push value still rides along on a push; only reads show data.
   assign rsp_strobe     = ctl_link[DEPTH].valid;
   assign rsp_read_value = ctl_link[DEPTH].rd ? data_link[DEPTH] : '0;
   assign rsp_status     = ctl_link[DEPTH].status;
   assign rsp_occupancy  = ctl_link[DEPTH].occupancy;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == cdq_pkg::STAT_OK ||
                      rsp_status == cdq_pkg::STAT_FULL ||
                      rsp_status == cdq_pkg::STAT_EMPTY))
      else $error("result carries an unknown status");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != cdq_pkg::STAT_OK) |-> rsp_read_value == '0)
      else $error("refused request returned data");

endmodule
